>>> src/mbc1_pkg.sv
package mbc1_pkg;

   localparam int ROM_CAPACITY_DEFAULT = 131072;
   localparam int RAM_CAPACITY_DEFAULT = 32768;

   localparam int ROM_SIZE_W   = 18;
   localparam int RAM_SIZE_W   = 16;
   localparam int CSR_DATA_W   = 18;
   localparam int ADDR_W       = 16;
   localparam int LOAD_W       = 17;
   localparam int BYTE_W       = 8;

   localparam int ROM_BANK_W   = 7;
   localparam int ROM_OFF_W    = 21;
   localparam int ROM_LIM_W    = 22;
   localparam int RAM_BANK_W   = 2;
   localparam int RAM_OFF_W    = 15;
   localparam int RAM_LIM_W    = 17;

   localparam logic [BYTE_W-1:0] BYTE_FF   = 8'hFF;
   localparam logic [3:0]        RAM_KEY   = 4'hA;

   typedef enum logic [1:0] {
      OP_READ     = 2'd0,
      OP_WRITE    = 2'd1,
      OP_LOAD_ROM = 2'd2,
      OP_LOAD_RAM = 2'd3
   } op_type;

   typedef enum logic [0:0] {
      CSR_ROM_SIZE = 1'b0,
      CSR_RAM_SIZE = 1'b1
   } csr_type;

   typedef enum logic [2:0] {
      REGION_RAM_EN   = 3'd0,
      REGION_ROM_LOW  = 3'd1,
      REGION_BANK_HI  = 3'd2,
      REGION_MODE     = 3'd3,
      REGION_VIDEO    = 3'd4,
      REGION_EXT_RAM  = 3'd5,
      REGION_WORK     = 3'd6,
      REGION_HIGH     = 3'd7
   } region_type;

   typedef enum logic [1:0] {
      SRC_ZERO = 2'd0,
      SRC_FF   = 2'd1,
      SRC_ROM  = 2'd2,
      SRC_RAM  = 2'd3
   } src_type;

endpackage

>>> src/mbc1_ram.sv
module mbc1_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/mbc1_bank_controller.sv
// Channel  | Ports                                                   | Direction
// req      | req_valid/req_ready, operation, bus_address, index, data | in
// rsp      | rsp_valid/rsp_ready, read_data                          | out
// csr      | csr_wr_en, csr_index, csr_wdata                         | in
//
// One item per cycle sustained while rsp_ready holds; an accepted item passes the
// registered read of the ROM and RAM stores, then the output register, before
// rsp_valid rises.
// Bank registers update at acceptance, so the next item sees them at once.
// Synchronous reset clears control state only; store contents stay undefined.
// A result waiting in the output register does not stop the next item; req_ready
// drops only when both the read stage and the output register hold items.
module mbc1_bank_controller
   import mbc1_pkg::*;
#(
   parameter int ROM_CAPACITY = ROM_CAPACITY_DEFAULT,
   parameter int RAM_CAPACITY = RAM_CAPACITY_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_operation,
   input  logic [ADDR_W-1:0]     req_bus_address,
   input  logic [LOAD_W-1:0]     req_load_index,
   input  logic [BYTE_W-1:0]     req_data_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [BYTE_W-1:0]     rsp_read_data,
   input  logic                  csr_wr_en,
   input  logic [0:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ROM_AW = $clog2(ROM_CAPACITY);
   localparam int RAM_AW = $clog2(RAM_CAPACITY);
   localparam logic [ROM_LIM_W-1:0] ROM_CAP_L = ROM_LIM_W'(ROM_CAPACITY);
   localparam logic [RAM_LIM_W-1:0] RAM_CAP_L = RAM_LIM_W'(RAM_CAPACITY);
   localparam logic [ROM_SIZE_W-1:0] ROM_SIZE_RESET = ROM_SIZE_W'(131072);

   logic [ROM_SIZE_W-1:0] rom_size_ff;
   logic [RAM_SIZE_W-1:0] ram_size_ff;
   logic [ROM_BANK_W-1:0] rom_bank_ff, rom_bank_in;
   logic [RAM_BANK_W-1:0] ram_bank_ff, ram_bank_in;
   logic                  ram_en_ff, ram_en_in;
   logic                  mode_ff, mode_in;

   logic    s1_valid_ff, s1_valid_in;
   src_type s1_src_ff, s1_src_in;
   logic    out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_data_ff, out_data_in;

   logic accept, s1_adv;
   region_type region;
   logic [ROM_LIM_W-1:0] rom_limit, rom_off;
   logic [RAM_LIM_W-1:0] ram_limit, ram_off;
   logic [ROM_BANK_W-1:0] read_bank;
   logic [4:0] low_bits;
   logic rom_hit, ram_hit, rom_load_ok, ram_load_ok;

   logic              rom_we, rom_re, ram_we, ram_re;
   logic [ROM_AW-1:0] rom_waddr, rom_raddr;
   logic [RAM_AW-1:0] ram_waddr, ram_raddr;
   logic [BYTE_W-1:0] rom_q, ram_q;

   assign s1_adv    = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign accept    = req_valid && req_ready;

   assign region    = region_type'(req_bus_address[ADDR_W-1:ADDR_W-3]);
   assign rom_limit = (ROM_LIM_W'(rom_size_ff) < ROM_CAP_L) ? ROM_LIM_W'(rom_size_ff)
                                                             : ROM_CAP_L;
   assign ram_limit = (RAM_LIM_W'(ram_size_ff) < RAM_CAP_L) ? RAM_LIM_W'(ram_size_ff)
                                                             : RAM_CAP_L;
   assign read_bank = req_bus_address[14] ? rom_bank_ff : '0;
   assign rom_off   = ROM_LIM_W'({read_bank, req_bus_address[13:0]});
   assign ram_off   = RAM_LIM_W'({ram_bank_ff, req_bus_address[12:0]});
   assign rom_hit   = rom_off < rom_limit;
   assign ram_hit   = ram_en_ff && (ram_off < ram_limit);
   assign rom_load_ok = ROM_LIM_W'(req_load_index) < ROM_CAP_L;
   assign ram_load_ok = RAM_LIM_W'(req_load_index) < RAM_CAP_L;
   assign low_bits  = (req_data_byte[4:0] == 5'd0) ? 5'd1 : req_data_byte[4:0];

   always_comb begin
      rom_bank_in = rom_bank_ff;
      ram_bank_in = ram_bank_ff;
      ram_en_in   = ram_en_ff;
      mode_in     = mode_ff;
      s1_src_in   = s1_src_ff;
      rom_we    = 1'b0;
      rom_re    = 1'b0;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      rom_waddr = ROM_AW'(req_load_index);
      rom_raddr = ROM_AW'(rom_off);
      ram_waddr = RAM_AW'(ram_off);
      ram_raddr = RAM_AW'(ram_off);
      if (accept) begin
         s1_src_in = SRC_ZERO;
         case (op_type'(req_operation))
            OP_READ: begin
               s1_src_in = SRC_FF;
               if (!req_bus_address[15] && rom_hit) begin
                  s1_src_in = SRC_ROM;
                  rom_re    = 1'b1;
               end else if (region == REGION_EXT_RAM && ram_hit) begin
                  s1_src_in = SRC_RAM;
                  ram_re    = 1'b1;
               end
            end
            OP_WRITE: begin
               case (region)
                  REGION_RAM_EN:  ram_en_in = (req_data_byte[3:0] == RAM_KEY);
                  REGION_ROM_LOW: rom_bank_in = {rom_bank_ff[6:5], low_bits};
                  REGION_BANK_HI: begin
                     if (mode_ff) begin
                        ram_bank_in = req_data_byte[1:0];
                     end else if (rom_bank_ff[4:0] == 5'd0) begin
                        rom_bank_in = {req_data_byte[1:0], 5'd1};
                     end else begin
                        rom_bank_in = {req_data_byte[1:0], rom_bank_ff[4:0]};
                     end
                  end
                  REGION_MODE:    mode_in = req_data_byte[0];
                  REGION_EXT_RAM: ram_we = ram_hit;
                  default: ;
               endcase
            end
            OP_LOAD_ROM: rom_we = rom_load_ok;
            OP_LOAD_RAM: begin
               ram_we    = ram_load_ok;
               ram_waddr = RAM_AW'(req_load_index);
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      s1_valid_in  = accept || (s1_valid_ff && !s1_adv);
      out_valid_in = s1_adv || (out_valid_ff && !rsp_ready);
      out_data_in  = out_data_ff;
      if (s1_adv) begin
         case (s1_src_ff)
            SRC_ROM: out_data_in = rom_q;
            SRC_RAM: out_data_in = ram_q;
            SRC_FF:  out_data_in = BYTE_FF;
            default: out_data_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_size_ff  <= ROM_SIZE_RESET;
         ram_size_ff  <= '0;
         rom_bank_ff  <= ROM_BANK_W'(1);
         ram_bank_ff  <= '0;
         ram_en_ff    <= 1'b0;
         mode_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en && csr_index == CSR_ROM_SIZE) begin
            rom_size_ff <= csr_wdata;
         end
         if (csr_wr_en && csr_index == CSR_RAM_SIZE) begin
            ram_size_ff <= csr_wdata[RAM_SIZE_W-1:0];
         end
         rom_bank_ff  <= rom_bank_in;
         ram_bank_ff  <= ram_bank_in;
         ram_en_ff    <= ram_en_in;
         mode_ff      <= mode_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      s1_src_ff   <= s1_src_in;
      out_data_ff <= out_data_in;
   end

   mbc1_ram #(.WIDTH(BYTE_W), .DEPTH(ROM_CAPACITY)) u_rom (
      .clock   (clock),
      .wr_en   (rom_we),
      .wr_addr (rom_waddr),
      .wr_data (req_data_byte),
      .rd_en   (rom_re),
      .rd_addr (rom_raddr),
      .rd_data (rom_q)
   );

   mbc1_ram #(.WIDTH(BYTE_W), .DEPTH(RAM_CAPACITY)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_data_byte),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_q)
   );

   assign rsp_valid     = out_valid_ff;
   assign rsp_read_data = out_data_ff;

endmodule

>>> src/mbc1_checker.sv
module mbc1_checker
   import mbc1_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [BYTE_W-1:0] rsp_read_data
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data))
      else $error("stalled item changed");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> ##1 rsp_valid)
      else $error("accepted item produced no result in time");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req_ready low with empty output");

endmodule

bind mbc1_bank_controller mbc1_checker u_checker (.*);
